/* rtl/kcet_pkg.sv */
// shared types, codes and constants of the key change event unit
// no dependencies; imported by every module of the block
`default_nettype none

package kcet_pkg;

  // key map geometry
  localparam int MAP_BYTES = 32;
  localparam int IDX_W     = 5;
  localparam int KEY_W     = 8;
  localparam int CODE_W    = 8;
  localparam int BIT_W     = 3;

  // result and counter widths
  localparam int KIND_W    = 2;
  localparam int CNT_W     = 16;
  localparam int REG_W     = 15;
  localparam int CFG_IDX_W = 2;

  // input operations
  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // typematic phases
  localparam logic [1:0] PHASE_IDLE   = 2'd0;
  localparam logic [1:0] PHASE_DELAY  = 2'd1;
  localparam logic [1:0] PHASE_REPEAT = 2'd2;

  // event kinds
  localparam logic [KIND_W-1:0] KIND_MAKE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BREAK  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REPEAT = 2'd2;
  localparam logic [KIND_W-1:0] KIND_MENU   = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_DELAY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_PERIOD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MENU_ACTIVE   = 2'd2;

  // reset values of the registers
  localparam logic [REG_W-1:0] RESET_DELAY  = 15'd7500;
  localparam logic [REG_W-1:0] RESET_PERIOD = 15'd1000;

  // special key codes
  localparam logic [CODE_W-1:0] MOD_FIRST  = 8'hE0;
  localparam logic [CODE_W-1:0] MOD_LAST   = 8'hE7;
  localparam logic [CODE_W-1:0] PAUSE_CODE = 8'h48;

  // classified work item handed from front to back
  typedef struct packed {
    logic             op;
    logic [IDX_W-1:0] idx;
    logic [KEY_W-1:0] bits;
    logic [KEY_W-1:0] diff;
    logic [KEY_W-1:0] emit;
  } job_t;

  // configuration registers
  typedef struct packed {
    logic [REG_W-1:0] delay;
    logic [REG_W-1:0] period;
    logic             menu;
  } cfg_t;

  // index of the lowest set bit of a key byte
  function automatic logic [BIT_W-1:0] low_bit_idx(input logic [KEY_W-1:0] v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = KEY_W - 1; i >= 0; i--) begin
      if (v[i]) r = BIT_W'(i);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/kcet_front.sv */
// front part: accepts beats, keeps the previous key map, classifies changes
// depends on kcet_pkg
`default_nettype none

module kcet_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      menu,
  input  wire logic                      accept,
  input  wire logic                      op,
  input  wire logic [kcet_pkg::IDX_W-1:0] byte_index,
  input  wire logic [kcet_pkg::KEY_W-1:0] key_bits,
  output logic                           push,
  output kcet_pkg::job_t                 push_job
);
  import kcet_pkg::*;

  logic [KEY_W-1:0] prior_r [MAP_BYTES];
  logic             in_map;
  logic [KEY_W-1:0] diff;
  logic [KEY_W-1:0] emit;
  logic [CODE_W-1:0] code;

  assign in_map = {1'b0, byte_index} < (IDX_W + 1)'(MAP_BYTES);
  assign diff   = prior_r[byte_index] ^ key_bits;

  // a changed bit yields an event unless it is a break that is dropped
  always_comb begin
    emit = '0;
    code = '0;
    for (int i = 0; i < KEY_W; i++) begin
      code    = {byte_index, BIT_W'(i)};
      emit[i] = diff[i] & (key_bits[i] | (!menu && code != PAUSE_CODE));
    end
  end

  // classified job: ticks always, key bytes only when something changed
  always_comb begin
    push_job.op   = op;
    push_job.idx  = byte_index;
    push_job.bits = key_bits;
    push_job.diff = diff;
    push_job.emit = emit;
    push = accept && ((op == OP_TICK) || (in_map && diff != '0));
  end

  // previous key map image
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAP_BYTES; i++) prior_r[i] <= '0;
    end else if (accept && op == OP_KEY && in_map) begin
      prior_r[byte_index] <= key_bits;
    end
  end

endmodule

`default_nettype wire

/* rtl/kcet_queue.sv */
// two-entry job queue between the front and the back part
// depends on kcet_pkg
`default_nettype none

module kcet_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire kcet_pkg::job_t push_job,
  output logic                full,
  input  wire logic           pop,
  output logic                valid,
  output kcet_pkg::job_t      head
);
  import kcet_pkg::*;

  job_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full  = count_r == 2'd2;
  assign valid = count_r != 2'd0;
  assign head  = mem_r[rd_ptr_r];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) count_nxt = count_r + 2'd1;
    else if (pop && !push) count_nxt = count_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

endmodule

`default_nettype wire

/* rtl/kcet_back.sv */
// back part: walks changed bits one a cycle unless an event waits at the output,
// runs typematic state, drives results; depends on kcet_pkg
`default_nettype none

module kcet_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire kcet_pkg::cfg_t              cfg,
  input  wire logic                        q_valid,
  input  wire kcet_pkg::job_t              q_head,
  output logic                             q_pop,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [kcet_pkg::CODE_W-1:0]      out_key_code,
  output logic [kcet_pkg::KIND_W-1:0]      out_event_kind,
  output logic                             out_last
);
  import kcet_pkg::*;

  logic              busy_r, busy_nxt;
  job_t              job_r, job_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic [CODE_W-1:0] key_r, key_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CODE_W-1:0] out_code_r;
  logic [KIND_W-1:0] out_kind_r;
  logic              out_last_r;

  logic              ld;
  logic [CODE_W-1:0] ld_code;
  logic [KIND_W-1:0] ld_kind;
  logic              ld_last;
  logic              load_ok;
  logic [KEY_W-1:0]  low;
  logic [CODE_W-1:0] code;
  logic [CNT_W-1:0]  cnt_inc;
  logic              emits;
  logic              make;
  logic              is_mod;

  assign load_ok = !out_valid_r || out_ready;
  assign low     = job_r.diff & (~job_r.diff + KEY_W'(1));
  assign code    = {job_r.idx, low_bit_idx(job_r.diff)};
  assign cnt_inc = (count_r != '1) ? count_r + CNT_W'(1) : count_r;
  assign emits   = |(job_r.emit & low);
  assign make    = |(job_r.bits & low);
  assign is_mod  = (code >= MOD_FIRST) && (code <= MOD_LAST);

  // job sequencing and typematic state
  always_comb begin
    busy_nxt  = busy_r;
    job_nxt   = job_r;
    phase_nxt = phase_r;
    key_nxt   = key_r;
    count_nxt = count_r;
    q_pop     = 1'b0;
    ld        = 1'b0;
    ld_code   = code;
    ld_kind   = KIND_MAKE;
    ld_last   = 1'b1;
    if (!busy_r) begin
      // take the next job
      if (q_valid) begin
        q_pop    = 1'b1;
        busy_nxt = 1'b1;
        job_nxt  = q_head;
      end
    end else if (job_r.op == OP_TICK) begin
      // timer tick
      ld_code = key_r;
      ld_kind = KIND_REPEAT;
      if (phase_r == PHASE_DELAY) begin
        busy_nxt = 1'b0;
        if (cnt_inc > {1'b0, cfg.delay}) begin
          phase_nxt = PHASE_REPEAT;
          count_nxt = CNT_W'(1);
        end else begin
          count_nxt = cnt_inc;
        end
      end else if (phase_r == PHASE_REPEAT) begin
        if (cnt_inc > {1'b0, cfg.period}) begin
          if (load_ok) begin
            ld        = 1'b1;
            count_nxt = CNT_W'(1);
            busy_nxt  = 1'b0;
          end
        end else begin
          count_nxt = cnt_inc;
          busy_nxt  = 1'b0;
        end
      end else begin
        busy_nxt = 1'b0;
      end
    end else begin
      // key byte: lowest pending changed bit this cycle
      if (!emits || load_ok) begin
        ld      = emits;
        ld_kind = make ? (cfg.menu ? KIND_MENU : KIND_MAKE) : KIND_BREAK;
        ld_last = (job_r.emit & job_r.diff & ~low) == '0;
        if (make && !cfg.menu && !is_mod) begin
          key_nxt   = code;
          phase_nxt = PHASE_DELAY;
          count_nxt = CNT_W'(1);
        end else if (!make && !cfg.menu && code == key_r) begin
          key_nxt   = '0;
          phase_nxt = PHASE_IDLE;
          count_nxt = '0;
        end
        job_nxt.diff = job_r.diff & ~low;
        if (job_nxt.diff == '0) busy_nxt = 1'b0;
      end
    end
  end

  // output register handshake
  always_comb begin
    if (ld) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      phase_r     <= PHASE_IDLE;
      key_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      phase_r     <= phase_nxt;
      key_r       <= key_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    if (ld) begin
      out_code_r <= ld_code;
      out_kind_r <= ld_kind;
      out_last_r <= ld_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_key_code   = out_code_r;
  assign out_event_kind = out_kind_r;
  assign out_last       = out_last_r;

endmodule

`default_nettype wire

/* rtl/key_change_events_with_typematic_unit.sv */
// top level of the key change event unit with typematic repeat
// depends on kcet_pkg, kcet_front, kcet_queue, kcet_back
`default_nettype none

// Takes key map bytes (op 0) and timer ticks (op 1) and emits make, break,
// repeat-make and menu-press events one per result beat, with last set on the
// final event of each input beat. The front keeps the 32-byte previous key map,
// updates it and classifies a byte in the cycle it is accepted; an unchanged
// byte ends there. A two-entry queue feeds the back, whose bit-serial loop sets
// the sustained rate: one changed bit per cycle while the output takes results;
// a key byte needs a load step, then its changed bits (1 to 8), a tick a load
// and an update step; no new job starts until done. Results sit in an output
// register, so the front accepts while one waits, until the queue fills. The
// configuration port takes a write every cycle; writes belong in idle time.

module key_change_events_with_typematic_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_op,
  input  wire logic [kcet_pkg::IDX_W-1:0]    in_byte_index,
  input  wire logic [kcet_pkg::KEY_W-1:0]    in_key_bits,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [kcet_pkg::CODE_W-1:0]        out_key_code,
  output logic [kcet_pkg::KIND_W-1:0]        out_event_kind,
  output logic                               out_last,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [kcet_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [kcet_pkg::REG_W-1:0]    cfg_data
);
  import kcet_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic in_accept;
  logic q_push;
  job_t q_push_job;
  logic q_full;
  logic q_pop;
  logic q_valid;
  job_t q_head;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign in_accept = in_valid && in_ready;

  // configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_REPEAT_DELAY:  cfg_nxt.delay  = cfg_data;
        CFG_REPEAT_PERIOD: cfg_nxt.period = cfg_data;
        CFG_MENU_ACTIVE:   cfg_nxt.menu   = cfg_data[0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delay  <= RESET_DELAY;
      cfg_r.period <= RESET_PERIOD;
      cfg_r.menu   <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  kcet_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .menu       (cfg_r.menu),
    .accept     (in_accept),
    .op         (in_op),
    .byte_index (in_byte_index),
    .key_bits   (in_key_bits),
    .push       (q_push),
    .push_job   (q_push_job)
  );

  kcet_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_push_job),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  kcet_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .q_valid        (q_valid),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_key_code   (out_key_code),
    .out_event_kind (out_event_kind),
    .out_last       (out_last)
  );

  // queue is never written when full
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("job queue written while full");

  // back only takes a job that is present
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("job queue read while empty");

  // menu mode yields no plain makes and no breaks
  a_menu_kinds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && cfg_r.menu) |->
      (out_event_kind != KIND_BREAK && out_event_kind != KIND_MAKE))
    else $error("plain make or break in menu mode");

  // pause never reports a break
  a_no_pause_break: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_kind == KIND_BREAK) |-> out_key_code != PAUSE_CODE)
    else $error("break of pause reported");

endmodule

`default_nettype wire
